// ----- sv/vfp_pkg.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser package
// Shared constants, codes and the command type passed from the byte front end
// to the state back end.
// ----------------------------------------------------------------------------
package vfp_pkg;

  // Frame store size; must cover the highest frame position (24).
  localparam int FRAME_STORE_DEPTH = 32;
  localparam int STORE_AW          = $clog2(FRAME_STORE_DEPTH);
  localparam int POS_W             = 5;

  // Command queue between front and back end.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // Frame bytes.
  localparam logic [7:0]       SYNC_BYTE = 8'hAA;
  localparam logic [7:0]       VER_BYTE  = 8'h05;
  localparam logic [7:0]       TYPE_BLOB = 8'h41;
  localparam logic [7:0]       TYPE_LINE = 8'h42;
  localparam logic [7:0]       MAX_LEN   = 8'd20;
  localparam logic [POS_W-1:0] HDR_LEN   = 5'd5;

  // Configuration port.
  localparam int               CFG_AW         = 3;
  localparam logic [CFG_AW-3:0] REG_IDX_LIMIT = '0;
  localparam logic [15:0]      LIMIT_RESET    = 16'd1000;

  // Mode codes.
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_BLOB = 2'd1;
  localparam logic [1:0] MODE_LINE = 2'd2;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_BLOB  = 2'd1,
    EV_LINE  = 2'd2,
    EV_CKERR = 2'd3
  } event_t;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_BLOB  = 3'd1,
    CMD_LINE  = 3'd2,
    CMD_CKERR = 3'd3,
    CMD_TICK  = 3'd4
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  tick_ms;
    logic [7:0]  status;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  period;
    logic [7:0]  marker;
    logic [15:0] angle;
    logic [15:0] deviation;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

// ----- sv/vfp_if.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser channels
// Input item channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vfp_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] data_byte;
  logic [7:0] tick_ms;

  modport source (output valid, opcode, data_byte, tick_ms, input ready);
  modport sink   (input valid, opcode, data_byte, tick_ms, output ready);
endinterface

interface vfp_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        event_res;
  logic [1:0]        mode;
  logic              offline;
  logic [7:0]        found_status;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [7:0]        frame_period_ms;
  logic [7:0]        marker_flag;
  logic signed [15:0] line_angle;
  logic signed [15:0] line_deviation;

  modport source (output valid, event_res, mode, offline, found_status, pos_x, pos_y,
                  frame_period_ms, marker_flag, line_angle, line_deviation,
                  input ready);
  modport sink   (input valid, event_res, mode, offline, found_status, pos_x, pos_y,
                  frame_period_ms, marker_flag, line_angle, line_deviation,
                  output ready);
endinterface

// ----- sv/vision_frame_parser_with_timeout_core.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser with timeout
// Frames camera UART bytes, checks the additive checksum, decodes blob and
// line frames into held fields and tracks camera silence from time ticks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Contents
//  in_ch    input      valid/ready         opcode, data_byte, tick_ms
//  out_ch   output     valid/ready         event, mode, offline, held fields
//  cfg_*    input      APB write/read      offline_limit_ms at byte address 0
//
// One item per cycle is accepted while the queue has room. An input transfer
// is written into the command queue and moves on into the output register
// once that register is empty or its result is being transferred. Each byte
// is handled as it arrives thanks to a running checksum. Reset is synchronous
// and clears the parser, the frame store and all held values. A stalled output
// holds one result and fills the two-entry queue, after which in_ch.ready drops
// until a result is transferred.
// ----------------------------------------------------------------------------
module vision_frame_parser_with_timeout_core import vfp_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  vfp_in_if.sink            in_ch,
  vfp_out_if.source         out_ch,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  logic [15:0] limit_r;
  logic        cfg_hit;
  logic        q_push;
  logic        q_pop;
  cmd_t        push_cmd;
  cmd_t        head_cmd;
  q_status_t   q_stat;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_IDX_LIMIT);
  assign cfg_prdata = cfg_hit ? {16'd0, limit_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      limit_r <= cfg_pwdata[15:0];
    end
  end

  vfp_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_cmd  (push_cmd)
  );

  vfp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head_cmd),
    .stat     (q_stat)
  );

  vfp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .limit  (limit_r),
    .q_stat (q_stat),
    .q_cmd  (head_cmd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // A decoded blob frame always leaves the camera online in blob mode.
  a_blob_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res == EV_BLOB |-> out_ch.mode == MODE_BLOB && !out_ch.offline)
    else $error("blob event without blob mode");

  a_line_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.event_res == EV_LINE |-> out_ch.mode == MODE_LINE && !out_ch.offline)
    else $error("line event without line mode");

  // Going offline clears the mode, and only a decoded frame sets it again.
  a_offline_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.offline |-> out_ch.mode == MODE_NONE)
    else $error("offline with a mode set");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

endmodule

// ----- sv/vfp_front.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser front end
// Accepts items, tracks frame position and running checksum, keeps the frame
// store and turns each item into one command for the back end.
// ----------------------------------------------------------------------------
module vfp_front import vfp_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  vfp_in_if.sink         in_ch,
  input  q_status_t      q_stat,
  output logic           q_push,
  output cmd_t           q_cmd
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [7:0]       store_r [FRAME_STORE_DEPTH];
  logic [7:0]       view    [FRAME_STORE_DEPTH];
  logic [7:0]       b;
  logic             accept;
  cmd_kind_t        kind;

  assign b           = in_ch.data_byte;
  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && !q_stat.full;
  assign q_push      = accept;

  // The byte being received is visible to the decode in the same cycle.
  always_comb begin
    for (int i = 0; i < FRAME_STORE_DEPTH; i++) begin
      view[i] = (STORE_AW'(pos_r) == STORE_AW'(i)) ? b : store_r[i];
    end
  end

  always_comb begin
    pos_nxt = pos_r;
    len_nxt = len_r;
    sum_nxt = (pos_r == '0) ? b : sum_r + b;
    kind    = in_ch.opcode ? CMD_TICK : CMD_NONE;
    if (!in_ch.opcode) begin
      priority if (pos_r == 5'd0) begin
        pos_nxt = (b == SYNC_BYTE) ? 5'd1 : 5'd0;
      end else if (pos_r == 5'd1) begin
        pos_nxt = 5'd2;
      end else if (pos_r == 5'd2) begin
        pos_nxt = (b == VER_BYTE) ? 5'd3 : 5'd0;
      end else if (pos_r == 5'd3) begin
        pos_nxt = (b == TYPE_BLOB || b == TYPE_LINE) ? 5'd4 : 5'd0;
      end else if (pos_r == 5'd4) begin
        if (b < MAX_LEN) begin
          len_nxt = b[POS_W-1:0];
          pos_nxt = HDR_LEN;
        end else begin
          pos_nxt = 5'd0;
        end
      end else if (pos_r >= len_r + HDR_LEN) begin
        if (sum_r == b) begin
          kind = (view[3] == TYPE_BLOB) ? CMD_BLOB : CMD_LINE;
        end else begin
          kind = CMD_CKERR;
        end
        pos_nxt = 5'd0;
      end else begin
        pos_nxt = pos_r + 5'd1;
      end
    end
  end

  // Field layout differs between blob and line frames.
  always_comb begin
    q_cmd         = '0;
    q_cmd.kind    = kind;
    q_cmd.tick_ms = in_ch.tick_ms;
    if (kind == CMD_BLOB) begin
      q_cmd.marker = view[5];
      q_cmd.status = view[6];
      q_cmd.pos_x  = {view[7], view[8]};
      q_cmd.pos_y  = {view[9], view[10]};
      q_cmd.period = view[11];
    end else begin
      q_cmd.status    = view[5];
      q_cmd.angle     = {view[6], view[7]};
      q_cmd.deviation = {view[8], view[9]};
      q_cmd.marker    = view[10];
      q_cmd.pos_x     = {view[11], view[12]};
      q_cmd.pos_y     = {view[13], view[14]};
      q_cmd.period    = view[15];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
      sum_r <= '0;
      for (int i = 0; i < FRAME_STORE_DEPTH; i++) begin
        store_r[i] <= '0;
      end
    end else if (accept && !in_ch.opcode) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
      store_r[STORE_AW'(pos_r)] <= b;
    end
  end

endmodule

// ----- sv/vfp_queue.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser command queue
// Short first-in first-out buffer between the front and back end.
// ----------------------------------------------------------------------------
module vfp_queue import vfp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output cmd_t      head,
  output q_status_t stat
);

  cmd_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r;
  logic [QUEUE_AW-1:0] rd_ptr_r;
  logic [QUEUE_CW-1:0] count_r;

  assign stat.full  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign stat.empty = (count_r == '0);
  assign head       = mem_r[rd_ptr_r];

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ----- sv/vfp_back.sv -----
// ----------------------------------------------------------------------------
// Vision frame parser back end
// Applies commands to the held fields, mode, offline flag and silence counter
// and presents one result per command in the output register.
// ----------------------------------------------------------------------------
module vfp_back import vfp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] limit,
  input  q_status_t   q_stat,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  vfp_out_if.source   out_ch
);

  logic        out_valid_r;
  event_t      ev_r;
  logic [16:0] silence_r;
  logic [1:0]  mode_r;
  logic        offline_r;
  logic [7:0]  status_r;
  logic [15:0] x_r;
  logic [15:0] y_r;
  logic [7:0]  period_r;
  logic [7:0]  marker_r;
  logic [15:0] angle_r;
  logic [15:0] dev_r;

  // The held state doubles as the output register, so it only moves when
  // the previous result has been transferred.
  assign q_pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.event_res       = ev_r;
  assign out_ch.mode            = mode_r;
  assign out_ch.offline         = offline_r;
  assign out_ch.found_status    = status_r;
  assign out_ch.pos_x           = x_r;
  assign out_ch.pos_y           = y_r;
  assign out_ch.frame_period_ms = period_r;
  assign out_ch.marker_flag     = marker_r;
  assign out_ch.line_angle      = angle_r;
  assign out_ch.line_deviation  = dev_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ev_r        <= EV_NONE;
      silence_r   <= '0;
      mode_r      <= MODE_NONE;
      offline_r   <= 1'b0;
      status_r    <= '0;
      x_r         <= '0;
      y_r         <= '0;
      period_r    <= '0;
      marker_r    <= '0;
      angle_r     <= '0;
      dev_r       <= '0;
    end else begin
      if (q_pop) begin
        out_valid_r <= 1'b1;
        unique case (q_cmd.kind)
          CMD_BLOB, CMD_LINE: begin
            status_r  <= q_cmd.status;
            x_r       <= q_cmd.pos_x;
            y_r       <= q_cmd.pos_y;
            period_r  <= q_cmd.period;
            marker_r  <= q_cmd.marker;
            silence_r <= '0;
            offline_r <= 1'b0;
            if (q_cmd.kind == CMD_LINE) begin
              angle_r <= q_cmd.angle;
              dev_r   <= q_cmd.deviation;
              mode_r  <= MODE_LINE;
              ev_r    <= EV_LINE;
            end else begin
              mode_r  <= MODE_BLOB;
              ev_r    <= EV_BLOB;
            end
          end
          CMD_CKERR: begin
            ev_r <= EV_CKERR;
          end
          CMD_TICK: begin
            ev_r <= EV_NONE;
            // The limit is tested before the time is added.
            if (silence_r < {1'b0, limit}) begin
              silence_r <= silence_r + {9'd0, q_cmd.tick_ms};
            end else begin
              offline_r <= 1'b1;
              mode_r    <= MODE_NONE;
            end
          end
          default: begin
            ev_r <= EV_NONE;
          end
        endcase
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ----- tb/vision_frame_parser_with_timeout_core_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Vision frame parser with timeout: block test
// Feeds camera bytes and time ticks through the input channel and checks every
// result against an independent prediction of framing, checksum, field
// decode and the silence timeout. The offline limit is changed between
// phases, both channels idle at random, and the result side is held off once
// long enough to back up the input.
// ----------------------------------------------------------------------------
module vision_frame_parser_with_timeout_core_test;
  import vfp_pkg::*;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;
  localparam logic [CFG_AW-1:0] LIMIT_ADDR = {REG_IDX_LIMIT, 2'b00};

  typedef struct packed {
    event_t      ev;
    logic [1:0]  mode;
    logic        offline;
    logic [7:0]  status;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  period;
    logic [7:0]  marker;
    logic [15:0] angle;
    logic [15:0] deviation;
  } camera_report_t;

  class camera_scoreboard;
    logic [15:0]      limit_ms;
    logic [POS_W-1:0] rx_pos;
    logic [POS_W-1:0] frame_len;
    logic [7:0]       store [FRAME_STORE_DEPTH];
    logic [16:0]      silence_ms;
    logic [1:0]       mode;
    logic             offline;
    logic [7:0]       status;
    logic [7:0]       period;
    logic [7:0]       marker;
    logic [15:0]      pos_x;
    logic [15:0]      pos_y;
    logic [15:0]      angle;
    logic [15:0]      deviation;
    camera_report_t   reports_due[$];
    int errors;
    int n_noted;
    int n_checked;
    int n_blob;
    int n_line;
    int n_ckerr;
    int n_silent_ticks;

    function void clear();
      limit_ms = LIMIT_RESET;
      rx_pos = '0;
      frame_len = '0;
      foreach (store[i]) store[i] = 8'h00;
      silence_ms = '0;
      mode = MODE_NONE;
      offline = 1'b0;
      status = '0;
      period = '0;
      marker = '0;
      pos_x = '0;
      pos_y = '0;
      angle = '0;
      deviation = '0;
      errors = 0;
      n_noted = 0;
      n_checked = 0;
      n_blob = 0;
      n_line = 0;
      n_ckerr = 0;
      n_silent_ticks = 0;
    endfunction

    function logic [15:0] word_at(int idx);
      return {store[idx], store[idx+1]};
    endfunction

    // The type byte of the frame just closed decides the layout.
    function event_t latch_fields();
      silence_ms = '0;
      offline = 1'b0;
      if (store[3] == TYPE_BLOB) begin
        marker = store[5];
        status = store[6];
        pos_x = word_at(7);
        pos_y = word_at(9);
        period = store[11];
        mode = MODE_BLOB;
        return EV_BLOB;
      end
      status = store[5];
      angle = word_at(6);
      deviation = word_at(8);
      marker = store[10];
      pos_x = word_at(11);
      pos_y = word_at(13);
      period = store[15];
      mode = MODE_LINE;
      return EV_LINE;
    endfunction

    function event_t parse_byte(logic [7:0] data_b);
      event_t ev;
      logic [7:0] sum;
      ev = EV_NONE;
      store[rx_pos] = data_b;
      case (rx_pos)
        5'd0: rx_pos = (data_b == SYNC_BYTE) ? 5'd1 : 5'd0;
        5'd1: rx_pos = 5'd2;
        5'd2: rx_pos = (data_b == VER_BYTE) ? 5'd3 : 5'd0;
        5'd3: rx_pos = (data_b == TYPE_BLOB || data_b == TYPE_LINE) ? 5'd4 : 5'd0;
        5'd4: begin
          if (data_b < MAX_LEN) begin
            frame_len = data_b[POS_W-1:0];
            rx_pos = HDR_LEN;
          end else begin
            rx_pos = '0;
          end
        end
        default: begin
          if (int'(rx_pos) >= int'(frame_len) + int'(HDR_LEN)) begin
            sum = 8'h00;
            for (int i = 0; i < int'(frame_len) + int'(HDR_LEN); i++) sum += store[i];
            if (sum == data_b) ev = latch_fields();
            else ev = EV_CKERR;
            rx_pos = '0;
          end else begin
            rx_pos = rx_pos + 1'b1;
          end
        end
      endcase
      return ev;
    endfunction

    // The limit is tested before the addition, so going offline takes one
    // more tick after the count has reached the limit.
    function void age_silence(logic [7:0] ms);
      if (silence_ms < {1'b0, limit_ms}) begin
        silence_ms = silence_ms + 17'(ms);
      end else begin
        offline = 1'b1;
        mode = MODE_NONE;
        n_silent_ticks++;
      end
    endfunction

    function void take_item(logic op, logic [7:0] data_b, logic [7:0] ms);
      camera_report_t r;
      r.ev = EV_NONE;
      if (op == OP_BYTE) r.ev = parse_byte(data_b);
      else age_silence(ms);
      case (r.ev)
        EV_BLOB: n_blob++;
        EV_LINE: n_line++;
        EV_CKERR: n_ckerr++;
        default: ;
      endcase
      r.mode = mode;
      r.offline = offline;
      r.status = status;
      r.pos_x = pos_x;
      r.pos_y = pos_y;
      r.period = period;
      r.marker = marker;
      r.angle = angle;
      r.deviation = deviation;
      reports_due.push_back(r);
      n_noted++;
    endfunction

    function void compare_field(string name, logic [15:0] want_v, logic [15:0] got_v);
      if (got_v !== want_v) begin
        $display("%0t: %s mismatch on result %0d, expected %h, actual %h",
                 $time, name, n_checked, want_v, got_v);
        errors++;
      end
    endfunction

    function void check_report(camera_report_t got);
      camera_report_t want;
      if (reports_due.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = reports_due.pop_front();
      compare_field("event_res", 16'(want.ev), 16'(got.ev));
      compare_field("mode", 16'(want.mode), 16'(got.mode));
      compare_field("offline", 16'(want.offline), 16'(got.offline));
      compare_field("found_status", 16'(want.status), 16'(got.status));
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("frame_period_ms", 16'(want.period), 16'(got.period));
      compare_field("marker_flag", 16'(want.marker), 16'(got.marker));
      compare_field("line_angle", want.angle, got.angle);
      compare_field("line_deviation", want.deviation, got.deviation);
      n_checked++;
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  bit                steady;
  camera_scoreboard  sb;

  vfp_in_if  in_ch ();
  vfp_out_if out_ch ();

  vision_frame_parser_with_timeout_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Leaves the port in the access phase; the caller closes the last transfer.
  task automatic cfg_access(input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= write;
    cfg_paddr <= LIMIT_ADDR;
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic set_offline_limit(input logic [15:0] value);
    logic [31:0] rd;
    cfg_access(1'b1, {16'($urandom), value}, rd);
    sb.limit_ms = value;
    cfg_access(1'b0, 32'h0, rd);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (rd[15:0] !== value) begin
      $display("%0t: offline_limit_ms read back, expected %h, actual %h",
               $time, value, rd[15:0]);
      sb.errors++;
    end
  endtask

  task automatic send_item(input logic op, input logic [7:0] data_b, input logic [7:0] ms);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.opcode <= op;
    in_ch.data_byte <= data_b;
    in_ch.tick_ms <= ms;
    do @(posedge clk); while (!in_ch.ready);
    sb.take_item(op, data_b, ms);
  endtask

  // Mostly well-formed frames with random content, plus tick bursts,
  // headers broken at each stage and loose noise bytes.
  task automatic send_random_sequence();
    logic [7:0] seq[$];
    logic [7:0] kind;
    logic [7:0] len;
    logic [7:0] sum;
    logic [7:0] junk;
    int pick;
    pick = $urandom_range(0, 99);
    steady = ($urandom_range(0, 7) == 0);
    if (pick < 70) begin
      kind = $urandom_range(0, 1) ? TYPE_LINE : TYPE_BLOB;
      case ($urandom_range(0, 3))
        0: len = (kind == TYPE_BLOB) ? 8'd7 : 8'd11;
        1: len = 8'd19;
        default: len = 8'($urandom_range(0, 19));
      endcase
      seq.push_back(SYNC_BYTE);
      seq.push_back(8'($urandom));
      seq.push_back(VER_BYTE);
      seq.push_back(kind);
      seq.push_back(len);
      repeat (len) seq.push_back(8'($urandom));
      sum = 8'h00;
      foreach (seq[i]) sum += seq[i];
      if ($urandom_range(0, 9) == 0) sum = sum ^ 8'(1 << $urandom_range(0, 7));
      seq.push_back(sum);
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 12)) send_item(OP_TICK, 8'($urandom), 8'($urandom));
    end else if (pick < 90) begin
      seq.push_back(SYNC_BYTE);
      seq.push_back(8'($urandom));
      case ($urandom_range(0, 2))
        0: seq.push_back(VER_BYTE ^ 8'($urandom_range(1, 255)));
        1: begin
          junk = 8'($urandom);
          if (junk == TYPE_BLOB || junk == TYPE_LINE) junk = 8'h00;
          seq.push_back(VER_BYTE);
          seq.push_back(junk);
        end
        default: begin
          seq.push_back(VER_BYTE);
          seq.push_back($urandom_range(0, 1) ? TYPE_LINE : TYPE_BLOB);
          seq.push_back(8'($urandom_range(20, 255)));
        end
      endcase
    end else begin
      repeat ($urandom_range(1, 4))
        seq.push_back(($urandom_range(0, 3) == 0) ? SYNC_BYTE : 8'($urandom));
    end
    foreach (seq[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(OP_TICK, 8'($urandom), 8'($urandom));
      send_item(OP_BYTE, seq[i], 8'($urandom));
    end
  endtask

  task automatic drain_results();
    int guard;
    in_ch.valid <= 1'b0;
    guard = 0;
    while (sb.reports_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin : result_sink
    int stall;
    bit held;
    camera_report_t got;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 5);
      // One long hold-off so the queue fills and the input stalls.
      if (!held && sb.n_checked >= 350) begin
        held = 1'b1;
        stall = 200;
      end
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.ev = event_t'(out_ch.event_res);
      got.mode = out_ch.mode;
      got.offline = out_ch.offline;
      got.status = out_ch.found_status;
      got.pos_x = out_ch.pos_x;
      got.pos_y = out_ch.pos_y;
      got.period = out_ch.frame_period_ms;
      got.marker = out_ch.marker_flag;
      got.angle = out_ch.line_angle;
      got.deviation = out_ch.line_deviation;
      sb.check_report(got);
    end
  end

  initial begin : stimulus
    logic [7:0] opening [25] = '{
      8'h00,
      8'hAA, 8'h11, 8'hAA,
      8'hAA, 8'h22, 8'h05, 8'hAA,
      8'hAA, 8'h33, 8'h05, 8'h42, 8'h14,
      8'hAA, 8'h44, 8'h05, 8'h41, 8'h00, 8'h34,
      8'hAA, 8'h55, 8'h05, 8'h42, 8'h00, 8'h47};
    logic [7:0] opening_ticks [6] = '{8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd9};
    logic [15:0] phase_limits [6];
    int quota;
    sb = new;
    sb.clear();
    steady = 1'b0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.opcode <= OP_BYTE;
    in_ch.data_byte <= 8'h00;
    in_ch.tick_ms <= 8'h00;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Header mismatches at each stage, a length of exactly 20, a short blob
    // frame that decodes stale store bytes, a bad check byte, then enough
    // silence to pass the reset limit.
    foreach (opening[i]) send_item(OP_BYTE, opening[i], 8'($urandom));
    foreach (opening_ticks[i]) send_item(OP_TICK, 8'($urandom), opening_ticks[i]);
    drain_results();

    phase_limits = '{16'd1, 16'd0, 16'($urandom_range(2, 3000)), 16'hFFFF,
                     16'($urandom_range(2, 3000)), LIMIT_RESET};
    foreach (phase_limits[p]) begin
      set_offline_limit(phase_limits[p]);
      quota = sb.n_noted + 200;
      while (sb.n_noted < quota) send_random_sequence();
      steady = 1'b0;
      while (!sb.offline) send_item(OP_TICK, 8'($urandom), 8'($urandom_range(128, 255)));
      send_item(OP_TICK, 8'($urandom), 8'($urandom));
      drain_results();
    end

    if (sb.reports_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.reports_due.size());
      sb.errors++;
    end
    $display("Covered %0d items: %0d blob frames, %0d line frames, %0d check errors.",
             sb.n_noted, sb.n_blob, sb.n_line, sb.n_ckerr);
    $display("Offline limits 0, 1, 1000, 65535 and two random values; %0d ticks past the limit.",
             sb.n_silent_ticks);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
